### sv/phcb_pkg.sv
`timescale 1ns / 1ps

package phcb_pkg;

	// Pointer index layout
	localparam int INDEX_W   = 16;
	localparam int PAGE_W    = 7;
	localparam int LINE_W    = 6;
	localparam int PAGE_LSB  = 9;
	localparam int LINE_LSB  = 3;
	localparam int NUM_LINES = 64;

	// At most this many hint words leave per set
	localparam int RESULT_CAP = 8;
	localparam int SLOTNUM_W  = 3;
	localparam int CNT_W      = 4;

	typedef struct packed {
		logic [INDEX_W-1:0] pointer_index;
		logic               first_of_set;
		logic               last_of_set;
	} item_t;

	typedef struct packed {
		logic [SLOTNUM_W-1:0] slot_number;
		logic [PAGE_W-1:0]    page_number;
		logic [NUM_LINES-1:0] cacheline_mask;
		logic                 final_slot;
	} hint_t;

	// Decoded item as it travels from front to back
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [LINE_W-1:0] line;
		logic              hinted;
		logic              first;
		logic              last;
	} entry_t;

endpackage

### sv/phcb_front.sv
`timescale 1ns / 1ps

module phcb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  phcb_pkg::item_t item,
	output logic            entry_valid,
	input  logic            entry_ready,
	output phcb_pkg::entry_t entry
);
	import phcb_pkg::*;

	logic   valid_s1;
	entry_t entry_s1;

	assign item_ready  = !valid_s1 || entry_ready;
	assign entry_valid = valid_s1;
	assign entry       = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Split index into page and cacheline; index zero carries no hint
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			entry_s1.page   <= item.pointer_index[PAGE_LSB +: PAGE_W];
			entry_s1.line   <= item.pointer_index[LINE_LSB +: LINE_W];
			entry_s1.hinted <= |item.pointer_index;
			entry_s1.first  <= item.first_of_set;
			entry_s1.last   <= item.last_of_set;
		end
	end

endmodule

### sv/phcb_queue.sv
`timescale 1ns / 1ps

module phcb_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  phcb_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output phcb_pkg::entry_t pop_data
);
	import phcb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/phcb_back.sv
`timescale 1ns / 1ps

module phcb_back #(
	parameter int MAX_SLOTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             entry_valid,
	output logic             entry_ready,
	input  phcb_pkg::entry_t entry,
	output logic             hint_valid,
	input  logic             hint_ready,
	output phcb_pkg::hint_t  hint
);
	import phcb_pkg::*;

	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int UW = $clog2(MAX_SLOTS + 1);

	logic [PAGE_W-1:0]    page_q [MAX_SLOTS];
	logic [NUM_LINES-1:0] mask_q [MAX_SLOTS];
	logic [UW-1:0]        used_q;
	logic                 emit_q;
	logic [CNT_W-1:0]     emit_idx_q;
	logic [CNT_W-1:0]     emit_n_q;
	logic                 out_valid_q;
	hint_t                out_q;

	logic                 pop;
	logic                 out_free;
	logic                 emit_step;
	logic                 emit_final;
	logic [UW-1:0]        used_base;
	logic [UW-1:0]        used_next;
	logic [MAX_SLOTS-1:0] match;
	logic                 alloc;
	logic [NUM_LINES-1:0] line_bit;
	logic [CNT_W-1:0]     emit_n;

	assign entry_ready = !emit_q;
	assign pop         = entry_valid && !emit_q;
	assign out_free    = !out_valid_q || hint_ready;
	assign emit_step   = emit_q && out_free;
	assign emit_final  = (CNT_W'(emit_idx_q + CNT_W'(1)) == emit_n_q);
	assign hint_valid  = out_valid_q;
	assign hint        = out_q;

	// Slot lookup: parallel compare against the filled slots
	always_comb begin
		used_base = entry.first ? '0 : used_q;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			match[s] = entry.hinted && (UW'(s) < used_base) && (page_q[s] == entry.page);
		end
		alloc     = entry.hinted && !(|match) && (used_base < UW'(MAX_SLOTS));
		line_bit  = NUM_LINES'(1) << entry.line;
		used_next = used_base + UW'(alloc);
		if (32'(used_next) > 32'(RESULT_CAP)) begin
			emit_n = CNT_W'(RESULT_CAP);
		end else begin
			emit_n = CNT_W'(used_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			emit_q      <= 1'b0;
			emit_idx_q  <= '0;
			emit_n_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				used_q     <= used_next;
				emit_idx_q <= '0;
				emit_n_q   <= emit_n;
				emit_q     <= entry.last && (emit_n != '0);
			end else if (emit_step) begin
				emit_idx_q <= emit_idx_q + CNT_W'(1);
				if (emit_final) begin
					emit_q <= 1'b0;
				end
			end
			if (emit_step) begin
				out_valid_q <= 1'b1;
			end else if (hint_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (pop && match[s]) begin
				mask_q[s] <= mask_q[s] | line_bit;
			end else if (pop && alloc && (UW'(s) == used_base)) begin
				page_q[s] <= entry.page;
				mask_q[s] <= line_bit;
			end
		end
		if (emit_step) begin
			out_q.slot_number    <= emit_idx_q[SLOTNUM_W-1:0];
			out_q.page_number    <= page_q[emit_idx_q[SW-1:0]];
			out_q.cacheline_mask <= mask_q[emit_idx_q[SW-1:0]];
			out_q.final_slot     <= emit_final;
		end
	end

endmodule

### sv/page_cacheline_hint_builder.sv
// page_cacheline_hint_builder
//
// Input channel (item_valid / item_ready / item): one word per pointer index with
// first_of_set and last_of_set markers. Index zero adds nothing to the hint.
// Output channel (hint_valid / hint_ready / hint): one word per filled slot, in
// slot order, after the word that carries last_of_set; final_slot marks the end.
//
// Throughput: one input word per cycle while the set is being built and the
// queue has room; the front register, the entry queue and the back's
// combinational slot compare all keep that rate. Closing a set holds the back
// while it reads one slot per cycle into the output register, as long as that
// register is free; the queue keeps taking input meanwhile until it fills.
// Path: the last_of_set word passes the front register, the queue and the back's
// emit state before its first hint word is loaded into the output register.
// Reset: clears valid flags, queue pointers and the slot count; no sweep needed.
// Stall: with hint_ready low the output register holds, emission pauses, then
// the queue and finally item_ready back up.

`timescale 1ns / 1ps

module page_cacheline_hint_builder #(
	parameter int MAX_SLOTS   = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  phcb_pkg::item_t item,
	output logic            hint_valid,
	input  logic            hint_ready,
	output phcb_pkg::hint_t hint
);
	import phcb_pkg::*;

	// front -> queue
	entry_t fq_data;
	logic   fq_valid;
	logic   fq_ready;

	// queue -> back
	entry_t qb_data;
	logic   qb_valid;
	logic   qb_ready;

	// Front: register and decode each word into page / cacheline
	phcb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.entry_valid (fq_valid),
		.entry_ready (fq_ready),
		.entry       (fq_data)
	);

	// Decoupling queue so intake continues while hints drain
	phcb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	// Back: slot table update and hint emission
	phcb_back #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (qb_valid),
		.entry_ready (qb_ready),
		.entry       (qb_data),
		.hint_valid  (hint_valid),
		.hint_ready  (hint_ready),
		.hint        (hint)
	);

endmodule

### sv/phcb_checker.sv
`timescale 1ns / 1ps

module phcb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            hint_valid,
	input logic            hint_ready,
	input phcb_pkg::hint_t hint
);
	import phcb_pkg::*;

	// A stalled hint word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hint_valid && !hint_ready |=> hint_valid && $stable(hint))
		else $error("hint word changed while stalled");

	// Every slot owns at least one cacheline
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		hint_valid |-> (hint.cacheline_mask != '0))
		else $error("empty cacheline mask emitted");

	// The eighth slot always closes the hint
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hint_valid && (hint.slot_number == SLOTNUM_W'(RESULT_CAP - 1)) |-> hint.final_slot)
		else $error("slot past the result cap");

	// Nothing is shown once reset has been seen at an edge
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !hint_valid)
		else $error("hint valid during reset");

endmodule

bind page_cacheline_hint_builder phcb_checker u_chk (.*);
